### hw/rtl/dfi_pkg.sv
`default_nettype none

package dfi_pkg;

    localparam int INDEX_W  = 11;
    localparam int OFFSET_W = 11;
    localparam int MODE_W   = 3;
    localparam int GEN_W    = 11;

    localparam int TABLE_DEPTH_DEFAULT = 2048;

    localparam logic [MODE_W-1:0] MODE_1 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_2 = 3'd2;
    localparam logic [MODE_W-1:0] MODE_3 = 3'd3;
    localparam logic [MODE_W-1:0] MODE_4 = 3'd4;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_1;

    localparam logic [3:0] GEN_MULT = 4'd13;

    typedef struct packed {
        logic [GEN_W-1:0] tu_mask;
        logic [GEN_W-1:0] v1;
        logic [GEN_W-1:0] lwb;
        logic [GEN_W-1:0] upb;
        logic [GEN_W-1:0] half;
    } mode_params_t;

    // Any unlisted mode falls back to mode 1
    function automatic mode_params_t mode_params(input logic [MODE_W-1:0] mode);
        mode_params_t p;
        case (mode)
            MODE_2:
            begin
                p.tu_mask = 11'd511;
                p.v1      = 11'd127;
                p.lwb     = 11'd64;
                p.upb     = 11'd448;
                p.half    = 11'd256;
            end
            MODE_3:
            begin
                p.tu_mask = 11'd255;
                p.v1      = 11'd63;
                p.lwb     = 11'd32;
                p.upb     = 11'd224;
                p.half    = 11'd128;
            end
            MODE_4:
            begin
                p.tu_mask = 11'd1023;
                p.v1      = 11'd255;
                p.lwb     = 11'd128;
                p.upb     = 11'd896;
                p.half    = 11'd512;
            end
            default:
            begin
                p.tu_mask = 11'd2047;
                p.v1      = 11'd511;
                p.lwb     = 11'd256;
                p.upb     = 11'd1792;
                p.half    = 11'd1024;
            end
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/dfi_if.sv
`default_nettype none

interface dfi_lookup_if
    import dfi_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] carrier_index;

    modport source (output valid, output carrier_index, input ready);
    modport sink   (input valid, input carrier_index, output ready);
endinterface

interface dfi_result_if
    import dfi_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [OFFSET_W-1:0] carrier_offset;
    logic                       index_out_of_range;

    modport source (output valid, output carrier_offset, output index_out_of_range, input ready);
    modport sink   (input valid, input carrier_offset, input index_out_of_range, output ready);
endinterface

`default_nettype wire

### hw/rtl/dab_frequency_interleaver_map.sv
`default_nettype none

// DAB frequency-interleaver map. After reset, and after every write of the
// transmission mode, the block builds the interleaving table by stepping the
// generator x = (13x + V1) mod Tu once per clock through all Tu values (Tu is
// 2048 in mode 1, 512 in mode 2, 256 in mode 3, 1024 in mode 4); lookup.ready
// stays low while it builds. Once built, one carrier index is accepted per cycle
// while the result side is not stalled; each lookup returns one result through
// the table memory's registered read port and then the output register. An index
// at or beyond the carrier count returns offset 0 with index_out_of_range set.
module dab_frequency_interleaver_map
    import dfi_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)
(
    input  wire                clk,
    input  wire                rst_n,
    dfi_lookup_if.sink         lookup,
    dfi_result_if.source       result,
    input  wire                cfg_wr_en,
    input  wire [MODE_W-1:0]   cfg_wr_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int FW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = INDEX_W + 1;

    typedef enum logic {
        ST_BUILD,
        ST_READY
    } state_t;

    state_t               state_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [GEN_W-1:0]     gen_x_reg;
    logic [GEN_W-1:0]     step_reg;
    logic [FW-1:0]        fill_reg;

    mode_params_t         params;
    logic [GEN_W+3:0]     gen_prod;
    logic [GEN_W-1:0]     gen_x_next;
    logic                 keep;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [OFFSET_W-1:0]  mem_wdata;

    logic [OFFSET_W-1:0]  mem [TABLE_DEPTH];
    logic [OFFSET_W-1:0]  rd_data_reg;

    logic                 s1_valid_reg;
    logic                 s1_oor_reg;
    logic                 out_valid_reg;
    logic [OFFSET_W-1:0]  out_offset_reg;
    logic                 out_oor_reg;

    logic                 out_load;
    logic                 lookup_fire;
    logic                 lookup_oor;

    assign params     = mode_params(mode_reg);
    assign gen_prod   = (GEN_W+4)'(GEN_MULT) * {4'd0, gen_x_reg} + {4'd0, params.v1};
    assign gen_x_next = gen_prod[GEN_W-1:0] & params.tu_mask;

    assign keep = (gen_x_reg != params.half) && (gen_x_reg >= params.lwb)
                  && (gen_x_reg <= params.upb) && (fill_reg < FW'(TABLE_DEPTH));

    assign mem_we    = (state_reg == ST_BUILD) && keep;
    assign mem_waddr = fill_reg[AW-1:0];
    assign mem_wdata = gen_x_reg - params.half;

    // Build sequencer; a mode write restarts the build
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BUILD;
            mode_reg  <= MODE_RESET;
            gen_x_reg <= '0;
            step_reg  <= '0;
            fill_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            state_reg <= ST_BUILD;
            mode_reg  <= cfg_wr_data;
            gen_x_reg <= '0;
            step_reg  <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_BUILD:
                begin
                    if (keep)
                    begin
                        fill_reg <= fill_reg + FW'(1);
                    end
                    gen_x_reg <= gen_x_next;
                    step_reg  <= step_reg + GEN_W'(1);
                    if (step_reg == params.tu_mask)
                    begin
                        state_reg <= ST_READY;
                    end
                end
                ST_READY:
                begin
                    state_reg <= ST_READY;
                end
                default:
                begin
                    state_reg <= ST_BUILD;
                end
            endcase
        end
    end

    // Lookup pipeline: memory read stage, then output register
    assign out_load     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign lookup.ready = (state_reg == ST_READY) && (!s1_valid_reg || out_load);
    assign lookup_fire  = lookup.valid && lookup.ready;
    assign lookup_oor   = CW'(lookup.carrier_index) >= CW'(fill_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (lookup_fire)
        begin
            rd_data_reg <= mem[lookup.carrier_index[AW-1:0]];
            s1_oor_reg  <= lookup_oor;
        end
        if (out_load)
        begin
            out_offset_reg <= s1_oor_reg ? '0 : rd_data_reg;
            out_oor_reg    <= s1_oor_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (lookup_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.carrier_offset     = $signed(out_offset_reg);
    assign result.index_out_of_range = out_oor_reg;

endmodule

`default_nettype wire

### hw/rtl/dfi_checker.sv
`default_nettype none

module dfi_checker
    import dfi_pkg::*;
(
    input wire                       clk,
    input wire                       rst_n,
    input wire                       lookup_valid,
    input wire                       lookup_ready,
    input wire                       result_valid,
    input wire                       result_ready,
    input wire signed [OFFSET_W-1:0] carrier_offset,
    input wire                       index_out_of_range,
    input wire                       cfg_wr_en
);

    // An out-of-range lookup always reports a zero offset
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && index_out_of_range) |-> (carrier_offset == '0))
        else $error("out-of-range result with non-zero offset");

    // A valid table entry is never the centre carrier and stays within the band
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !index_out_of_range) |->
            ((carrier_offset != '0) && (carrier_offset >= -11'sd768)
             && (carrier_offset <= 11'sd768)))
        else $error("table offset outside the carrier band");

    // A mode write starts a rebuild, so no lookup is taken in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !lookup_ready)
        else $error("lookup accepted during table build");

    // A rising result needs a matching earlier lookup, registered through the read stage and the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(result_valid) && $past(rst_n, 2)) |-> $past(lookup_valid && lookup_ready, 2))
        else $error("result without a matching lookup");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(carrier_offset) && $stable(index_out_of_range)))
        else $error("stalled result changed");

endmodule

bind dab_frequency_interleaver_map dfi_checker u_dfi_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .lookup_valid       (lookup.valid),
    .lookup_ready       (lookup.ready),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .carrier_offset     (result.carrier_offset),
    .index_out_of_range (result.index_out_of_range),
    .cfg_wr_en          (cfg_wr_en)
);

`default_nettype wire

### tb/tb_top.sv
`default_nettype none

module tb_top;
    import dfi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH   = TABLE_DEPTH_DEFAULT;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 82;
    localparam int NUM_PHASES    = 8;
    localparam int NUM_ROWS      = 23;
    localparam int GEN_FACTOR    = 13;

    // mode values with no setting of their own; they behave as mode 1
    localparam logic [MODE_W-1:0] MODE_ALIAS_0 = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ALIAS_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_ALIAS_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_ALIAS_7 = 3'd7;

    typedef struct {
        logic signed [OFFSET_W-1:0] offset;
        logic                       out_of_range;
    } lookup_result_t;

    typedef struct {
        bit                 typed;
        lookup_result_t     result;
    } override_t;

    typedef struct {
        bit                 set_mode;
        logic [MODE_W-1:0]  mode;
        logic [INDEX_W-1:0] index;
        bit                 typed;
        int                 offset;
        bit                 out_of_range;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [MODE_W-1:0] cfg_wr_data;

    dfi_lookup_if lookup_ch();
    dfi_result_if result_ch();

    dab_frequency_interleaver_map #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .lookup      (lookup_ch),
        .result      (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // predictor state: the permutation table for the current mode
    logic signed [OFFSET_W-1:0] perm_table [TABLE_DEPTH];
    int unsigned                stored_count;

    lookup_result_t pending_results [$];
    override_t      row_overrides [$];

    int unsigned cycle_count = 0;
    int unsigned err_count = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;

    dir_row_t dir_rows [NUM_ROWS] = '{
        '{1'b0, MODE_1,       11'd0,    1'b1, -513, 1'b0},
        '{1'b0, MODE_1,       11'd1535, 1'b0, 0,    1'b0},
        '{1'b0, MODE_1,       11'd1536, 1'b1, 0,    1'b1},
        '{1'b0, MODE_1,       11'd2047, 1'b1, 0,    1'b1},
        '{1'b0, MODE_1,       11'd1024, 1'b0, 0,    1'b0},
        '{1'b0, MODE_1,       11'd1023, 1'b0, 0,    1'b0},
        '{1'b1, MODE_2,       11'd0,    1'b1, -129, 1'b0},
        '{1'b0, MODE_2,       11'd383,  1'b0, 0,    1'b0},
        '{1'b0, MODE_2,       11'd384,  1'b1, 0,    1'b1},
        '{1'b1, MODE_3,       11'd0,    1'b1, -65,  1'b0},
        '{1'b0, MODE_3,       11'd191,  1'b0, 0,    1'b0},
        '{1'b0, MODE_3,       11'd192,  1'b1, 0,    1'b1},
        '{1'b0, MODE_3,       11'd1365, 1'b1, 0,    1'b1},
        '{1'b1, MODE_4,       11'd0,    1'b1, -257, 1'b0},
        '{1'b0, MODE_4,       11'd767,  1'b0, 0,    1'b0},
        '{1'b0, MODE_4,       11'd768,  1'b1, 0,    1'b1},
        '{1'b0, MODE_4,       11'd682,  1'b0, 0,    1'b0},
        '{1'b1, MODE_ALIAS_0, 11'd0,    1'b1, -513, 1'b0},
        '{1'b0, MODE_ALIAS_0, 11'd1536, 1'b1, 0,    1'b1},
        '{1'b1, MODE_ALIAS_7, 11'd1535, 1'b0, 0,    1'b0},
        '{1'b1, MODE_ALIAS_5, 11'd0,    1'b1, -513, 1'b0},
        '{1'b1, MODE_ALIAS_6, 11'd100,  1'b0, 0,    1'b0},
        '{1'b1, MODE_1,       11'd0,    1'b1, -513, 1'b0}
    };

    logic [MODE_W-1:0] phase_modes [NUM_PHASES] = '{
        MODE_2, MODE_3, MODE_4, MODE_ALIAS_0, MODE_ALIAS_7, MODE_1, MODE_3, MODE_2
    };

    always #2 clk = ~clk;

    function automatic void build_perm_table(input logic [MODE_W-1:0] mode);
        int unsigned tu;
        int unsigned v1;
        int unsigned lwb;
        int unsigned carriers;
        int unsigned upb;
        int unsigned half;
        int unsigned x;
        case (mode)
            MODE_2:
            begin
                tu = 512; v1 = 127; lwb = 64; carriers = 384;
            end
            MODE_3:
            begin
                tu = 256; v1 = 63; lwb = 32; carriers = 192;
            end
            MODE_4:
            begin
                tu = 1024; v1 = 255; lwb = 128; carriers = 768;
            end
            default:
            begin
                tu = 2048; v1 = 511; lwb = 256; carriers = 1536;
            end
        endcase
        upb = lwb + carriers;
        half = tu / 2;
        stored_count = 0;
        x = 0;
        for (int unsigned step = 0; step < tu; step++)
        begin
            if (step != 0)
                x = (GEN_FACTOR * x + v1) % tu;
            // drop the centre value and anything outside the band
            if (x != half && x >= lwb && x <= upb && stored_count < TABLE_DEPTH)
            begin
                perm_table[stored_count] = OFFSET_W'(int'(x) - int'(half));
                stored_count++;
            end
        end
    endfunction

    function automatic lookup_result_t predict_lookup(input logic [INDEX_W-1:0] index);
        lookup_result_t r;
        if (index >= stored_count)
        begin
            r.offset = '0;
            r.out_of_range = 1'b1;
        end
        else
        begin
            r.offset = perm_table[index];
            r.out_of_range = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0d: %s", cycle_count, what);
        err_count++;
    endtask

    // lookup and result transactions, sampled at the rising edge
    always @(posedge clk)
    begin
        lookup_result_t exp_r;
        override_t      ov;
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            if (lookup_ch.valid && lookup_ch.ready)
            begin
                exp_r = predict_lookup(lookup_ch.carrier_index);
                if (row_overrides.size() != 0)
                begin
                    ov = row_overrides.pop_front();
                    if (ov.typed)
                        exp_r = ov.result;
                end
                pending_results.push_back(exp_r);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with no lookup outstanding");
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (result_ch.carrier_offset !== exp_r.offset)
                        report_mismatch($sformatf("carrier_offset %0d, expected %0d",
                                        result_ch.carrier_offset, exp_r.offset));
                    if (result_ch.index_out_of_range !== exp_r.out_of_range)
                        report_mismatch($sformatf("index_out_of_range %0b, expected %0b",
                                        result_ch.index_out_of_range, exp_r.out_of_range));
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (receiver_stall_pct == 0)
            result_ch.ready <= 1'b1;
        else
            result_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_index(input logic [INDEX_W-1:0] index);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            lookup_ch.valid <= 1'b0;
            @(negedge clk);
        end
        lookup_ch.valid <= 1'b1;
        lookup_ch.carrier_index <= index;
        do
            @(posedge clk);
        while (!lookup_ch.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        lookup_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] mode);
        wait_drained();
        // hold off until the pipeline is surely empty
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        build_perm_table(mode);
    endtask

    initial
    begin
        override_t          ov;
        logic [INDEX_W-1:0] index;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = MODE_RESET;
        lookup_ch.valid = 1'b0;
        lookup_ch.carrier_index = '0;
        result_ch.ready = 1'b0;
        build_perm_table(MODE_RESET);
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].set_mode)
                write_mode(dir_rows[i].mode);
            ov.typed = dir_rows[i].typed;
            ov.result.offset = OFFSET_W'(dir_rows[i].offset);
            ov.result.out_of_range = dir_rows[i].out_of_range;
            row_overrides.push_back(ov);
            send_index(dir_rows[i].index);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_mode(phase_modes[p]);
            case (p % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
                default: begin sender_idle_pct = 6; receiver_stall_pct = 6; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // pause the sender until every result is back
                if (p == 1 && n == PHASE_ITEMS / 2)
                begin
                    wait_drained();
                    @(negedge clk);
                end
                if ($urandom_range(0, 99) < 85)
                    index = INDEX_W'($urandom_range(0, stored_count - 1));
                else
                    index = INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
                send_index(index);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
